// ===== design/midpoint_circle_octant_stepper_assert.svh =====
// ----------------------------------------------------------------------------
// Midpoint circle octant stepper - assertion macros
// Shared concurrent check forms, clocked and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MIDPOINT_CIRCLE_OCTANT_STEPPER_ASSERT_SVH
`define MIDPOINT_CIRCLE_OCTANT_STEPPER_ASSERT_SVH

// Same-cycle implication.
`define MCOS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mcos: same-cycle check failed");

// Next-cycle implication.
`define MCOS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mcos: next-cycle check failed");

`endif

// ===== design/mcos_pkg.sv =====
// ----------------------------------------------------------------------------
// mcos_pkg
// Widths, codes and helpers for the midpoint circle octant stepper.
// ----------------------------------------------------------------------------
package mcos_pkg;

    localparam int MAX_DIM    = 4096;
    localparam int COORD_BITS = 16;

    localparam int PIX_W     = 12;
    localparam int CTR_W     = 16;
    localparam int RAD_W     = 15;
    localparam int MASK_W    = 4;
    localparam int COLOR_W   = 32;
    localparam int OFF_W     = 16;
    localparam int ERR_W     = 18;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int NUM_PIX   = 8;
    localparam int SEL_W     = 3;

    // Signed width holding center plus or minus an offset
    localparam int CALC_W = ((COORD_BITS > OFF_W) ? COORD_BITS : OFF_W) + 2;
    localparam int CMP_W  = CALC_W + 1;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    // Quadrant mask bits
    localparam int QB_PXPY = 3;
    localparam int QB_MXPY = 2;
    localparam int QB_MXMY = 1;
    localparam int QB_PXMY = 0;

    // True when 0 <= v < lim and v < MAX_DIM
    function automatic logic in_image(input logic signed [CALC_W-1:0] v,
                                      input logic [CFG_W-1:0] lim);
        logic [CMP_W-1:0] vu;
        vu = {1'b0, v};
        in_image = !v[CALC_W-1] && (vu < CMP_W'(lim)) && (vu < CMP_W'(MAX_DIM));
    endfunction

endpackage

// ===== design/mcos_if.sv =====
// ----------------------------------------------------------------------------
// mcos channel interfaces
// Request, pixel result and configuration write channels.
// ----------------------------------------------------------------------------
interface mcos_req_if
    import mcos_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    req_type;
    logic signed [CTR_W-1:0] center_x;
    logic signed [CTR_W-1:0] center_y;
    logic [RAD_W-1:0]        radius;
    logic [MASK_W-1:0]       quadrant_en;
    logic [COLOR_W-1:0]      draw_color;

    modport source (output valid, req_type, center_x, center_y, radius, quadrant_en,
                    draw_color, input ready);
    modport sink   (input valid, req_type, center_x, center_y, radius, quadrant_en,
                    draw_color, output ready);
endinterface

interface mcos_pix_if
    import mcos_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [PIX_W-1:0]   pixel_x;
    logic [PIX_W-1:0]   pixel_y;
    logic [COLOR_W-1:0] pixel_rgba;
    logic               pixel_valid;
    logic               last_of_step;
    logic               circle_done;

    modport source (output valid, pixel_x, pixel_y, pixel_rgba, pixel_valid,
                    last_of_step, circle_done, input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_rgba, pixel_valid,
                    last_of_step, circle_done, output ready);
endinterface

interface mcos_cfg_if
    import mcos_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/midpoint_circle_octant_stepper.sv =====
// ----------------------------------------------------------------------------
// midpoint_circle_octant_stepper
// Steps a midpoint circle one octant step per request, emitting mirrored pixels.
// ----------------------------------------------------------------------------
// Channels: i_req takes start (load center, radius, mask, color) and step
// requests; o_pix returns results; i_cfg writes image width (index 0) and
// height (index 1) and is always ready.
// A request is evaluated in the cycle it transfers: the octant step updates
// the circle state and all eight mirrored candidates are clipped, masked and
// latched into a result buffer. Results appear on o_pix the next cycle and
// drain one per cycle in fixed order while the receiver is ready, set by
// the single result port (one transfer per cycle).
// A start, an idle step or a fully clipped step gives one status result.
// A new request is taken in the cycle the last buffered result transfers,
// so requests run back to back with no bubble.
// If the receiver stalls, the buffer holds and i_req.ready stays low.
// Reset (synchronous, active low) clears the circle state, the image size
// and the result buffer.
// ----------------------------------------------------------------------------
`include "midpoint_circle_octant_stepper_assert.svh"

module midpoint_circle_octant_stepper
    import mcos_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    mcos_req_if.sink   i_req,
    mcos_cfg_if.sink   i_cfg,
    mcos_pix_if.source o_pix
);

    // circle state
    logic signed [COORD_BITS-1:0] r_cx, r_cy;
    logic signed [OFF_W-1:0]      r_off_a, r_off_b, n_off_a, n_off_b;
    logic signed [ERR_W-1:0]      r_err, n_err;
    logic [MASK_W-1:0]            r_mask;
    logic [COLOR_W-1:0]           r_color;
    logic                         r_active, n_active;
    logic [CFG_W-1:0]             r_img_w, r_img_h;

    // result buffer
    logic                 r_busy;
    logic                 r_status;
    logic [NUM_PIX-1:0]   r_pend, n_pend;
    logic [PIX_W-1:0]     r_px [NUM_PIX];
    logic [PIX_W-1:0]     r_py [NUM_PIX];

    logic signed [CALC_W-1:0] cand_x [NUM_PIX];
    logic signed [CALC_W-1:0] cand_y [NUM_PIX];
    logic signed [CALC_W-1:0] cx_e, cy_e, a_e, b_e;
    logic signed [CALC_W-1:0] x_pa, x_ma, x_pb, x_mb, y_pa, y_ma, y_pb, y_mb;
    logic [NUM_PIX-1:0]       gate;
    logic signed [ERR_W-1:0]  err_inc;
    logic [SEL_W-1:0]         sel;
    logic [NUM_PIX-1:0]       pend_pop;
    logic                     out_last;
    logic                     req_xfer, pix_xfer;

    assign req_xfer = i_req.valid && i_req.ready;
    assign pix_xfer = o_pix.valid && o_pix.ready;

    // ---------------- candidate pixels ----------------
    assign cx_e = CALC_W'(r_cx);
    assign cy_e = CALC_W'(r_cy);
    assign a_e  = CALC_W'(r_off_a);
    assign b_e  = CALC_W'(r_off_b);

    // c - v - 1 == c + ~v
    assign x_pa = cx_e + a_e;
    assign x_ma = cx_e + ~a_e;
    assign x_pb = cx_e + b_e;
    assign x_mb = cx_e + ~b_e;
    assign y_pa = cy_e + a_e;
    assign y_ma = cy_e + ~a_e;
    assign y_pb = cy_e + b_e;
    assign y_mb = cy_e + ~b_e;

    always_comb begin
        cand_x[0] = x_pa; cand_y[0] = y_pb;
        cand_x[1] = x_pb; cand_y[1] = y_pa;
        cand_x[2] = x_ma; cand_y[2] = y_pb;
        cand_x[3] = x_pb; cand_y[3] = y_ma;
        cand_x[4] = x_pa; cand_y[4] = y_mb;
        cand_x[5] = x_mb; cand_y[5] = y_pa;
        cand_x[6] = x_ma; cand_y[6] = y_mb;
        cand_x[7] = x_mb; cand_y[7] = y_ma;
    end

    assign gate = {r_mask[QB_MXMY], r_mask[QB_MXMY], r_mask[QB_MXPY], r_mask[QB_PXMY],
                   r_mask[QB_PXMY], r_mask[QB_MXPY], r_mask[QB_PXPY], r_mask[QB_PXPY]};

    always_comb begin
        for (int k = 0; k < NUM_PIX; k++) begin
            n_pend[k] = gate[k] && in_image(cand_x[k], r_img_w)
                        && in_image(cand_y[k], r_img_h);
        end
    end

    // ---------------- octant step ----------------
    assign err_inc = (ERR_W'(r_off_b) <<< 1) + ERR_W'(2);

    always_comb begin
        logic signed [ERR_W-1:0] err_mid;
        err_mid = r_err + err_inc;
        n_off_b = r_off_b + OFF_W'(1);
        n_off_a = r_off_a;
        n_err   = err_mid;
        if (!err_mid[ERR_W-1]) begin
            n_off_a = r_off_a - OFF_W'(1);
            n_err   = err_mid - (ERR_W'(r_off_a) <<< 1) + ERR_W'(1);
        end
        n_active = (n_off_a >= n_off_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx     <= '0;
            r_cy     <= '0;
            r_off_a  <= '0;
            r_off_b  <= '0;
            r_err    <= '0;
            r_mask   <= '0;
            r_color  <= '0;
            r_active <= 1'b0;
        end else if (req_xfer) begin
            if (i_req.req_type == REQ_START) begin
                r_cx     <= i_req.center_x[COORD_BITS-1:0];
                r_cy     <= i_req.center_y[COORD_BITS-1:0];
                r_off_a  <= OFF_W'(i_req.radius) - OFF_W'(1);
                r_off_b  <= '0;
                r_err    <= -ERR_W'(i_req.radius);
                r_mask   <= i_req.quadrant_en;
                r_color  <= i_req.draw_color;
                r_active <= (i_req.radius != '0);
            end else if (r_active) begin
                r_off_a  <= n_off_a;
                r_off_b  <= n_off_b;
                r_err    <= n_err;
                r_active <= n_active;
            end
        end
    end

    // ---------------- configuration ----------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= '0;
            r_img_h <= '0;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == CFG_IMAGE_WIDTH) begin
                r_img_w <= i_cfg.data;
            end
            if (i_cfg.index == CFG_IMAGE_HEIGHT) begin
                r_img_h <= i_cfg.data;
            end
        end
    end

    // ---------------- result buffer ----------------
    always_comb begin
        sel = '0;
        for (int k = NUM_PIX - 1; k >= 0; k--) begin
            if (r_pend[k]) begin
                sel = SEL_W'(k);
            end
        end
    end

    assign pend_pop = r_pend & (r_pend - NUM_PIX'(1));
    assign out_last = r_status || (pend_pop == '0);

    assign i_req.ready = !r_busy || (o_pix.ready && out_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_status <= 1'b0;
            r_pend   <= '0;
        end else if (req_xfer) begin
            r_busy <= 1'b1;
            if (i_req.req_type == REQ_STEP && r_active && n_pend != '0) begin
                r_status <= 1'b0;
                r_pend   <= n_pend;
            end else begin
                r_status <= 1'b1;
                r_pend   <= '0;
            end
        end else if (pix_xfer) begin
            if (out_last) begin
                r_busy   <= 1'b0;
                r_status <= 1'b0;
                r_pend   <= '0;
            end else begin
                r_pend <= pend_pop;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_xfer) begin
            for (int k = 0; k < NUM_PIX; k++) begin
                r_px[k] <= cand_x[k][PIX_W-1:0];
                r_py[k] <= cand_y[k][PIX_W-1:0];
            end
        end
    end

    assign o_pix.valid        = r_busy;
    assign o_pix.pixel_valid  = !r_status;
    assign o_pix.pixel_x      = r_status ? '0 : r_px[sel];
    assign o_pix.pixel_y      = r_status ? '0 : r_py[sel];
    assign o_pix.pixel_rgba   = r_status ? '0 : r_color;
    assign o_pix.last_of_step = out_last;
    assign o_pix.circle_done  = !r_active;

    // ---------------- assertions ----------------
    `MCOS_ASSERT_IMP(a_status_is_last, i_clk, i_rst_n,
                     o_pix.valid && !o_pix.pixel_valid, o_pix.last_of_step)
    `MCOS_ASSERT_NXT(a_req_gives_result, i_clk, i_rst_n, req_xfer, o_pix.valid)
    `MCOS_ASSERT_IMP(a_active_order, i_clk, i_rst_n, r_active, r_off_a >= r_off_b)
    `MCOS_ASSERT_IMP(a_status_no_pend, i_clk, i_rst_n, r_status, r_pend == '0)

endmodule

// ===== dv/midpoint_circle_octant_stepper_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// midpoint_circle_octant_stepper_tb
// Drives start/step requests and image-size writes into the stepper. A local
// circle predictor tracks the octant state and clipping, and every pixel
// transfer is checked in order against the predicted stream. The run covers
// directed corner cases first, then random circles under varied idling.
// ----------------------------------------------------------------------------
module midpoint_circle_octant_stepper_tb;
    import mcos_pkg::*;

    localparam int  HALF_PERIOD   = 10;
    localparam int  RESET_CYCLES  = 5;
    localparam int  SETTLE_CYCLES = 8;
    localparam int  LIMIT_CYCLES  = 200000;
    localparam int  SIZED_FROM    = 5;   // directed rows before this run at reset image size
    localparam int  PHASE_ITEMS   = 20;

    // register indexes that the block decodes as nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [PIX_W-1:0]   x;
        logic [PIX_W-1:0]   y;
        logic [COLOR_W-1:0] color;
        logic               pix_ok;
        logic               last;
        logic               done;
    } t_pixel;

    typedef struct {
        logic                    kind;
        logic signed [CTR_W-1:0] cx;
        logic signed [CTR_W-1:0] cy;
        logic [RAD_W-1:0]        radius;
        logic [MASK_W-1:0]       mask;
        logic [COLOR_W-1:0]      color;
        bit                      typed;
        t_pixel                  want;
    } t_circle_req;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mcos_req_if req_if ();
    mcos_cfg_if cfg_if ();
    mcos_pix_if pix_if ();

    midpoint_circle_octant_stepper dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .i_cfg   (cfg_if),
        .o_pix   (pix_if)
    );

    // predicted circle state
    int               ctr_x    = 0;
    int               ctr_y    = 0;
    int               off_a    = 0;
    int               off_b    = 0;
    int               dec_err  = 0;
    logic [MASK_W-1:0]  mask_q  = '0;
    logic [COLOR_W-1:0] color_q = '0;
    bit               running  = 1'b0;
    int               img_w    = 0;
    int               img_h    = 0;

    t_pixel      pixel_expect_q[$];
    t_circle_req directed_rows[$];
    t_circle_req req_now;
    t_pixel      seen_pixel;
    t_pixel      want_pixel;
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    function automatic t_pixel status_result(input logic done_f);
        t_pixel p;
        p = '0;
        p.last = 1'b1;
        p.done = done_f;
        return p;
    endfunction

    // One request: update the circle and queue the pixels it emits, in order.
    function automatic void predict_octant_step(input t_circle_req rq);
        t_pixel found[$];
        t_pixel p;
        int     xs[8];
        int     ys[8];
        bit     en[8];
        int     w_lim;
        int     h_lim;
        int     a;
        int     b;
        w_lim = (img_w < MAX_DIM) ? img_w : MAX_DIM;
        h_lim = (img_h < MAX_DIM) ? img_h : MAX_DIM;
        if (rq.kind == REQ_START) begin
            ctr_x   = int'(rq.cx);
            ctr_y   = int'(rq.cy);
            off_a   = int'(rq.radius) - 1;
            off_b   = 0;
            dec_err = -int'(rq.radius);
            mask_q  = rq.mask;
            color_q = rq.color;
            running = (off_a >= off_b);
        end else if (running) begin
            a = off_a;
            b = off_b;
            xs[0] = ctr_x + a;     ys[0] = ctr_y + b;     en[0] = mask_q[QB_PXPY];
            xs[1] = ctr_x + b;     ys[1] = ctr_y + a;     en[1] = mask_q[QB_PXPY];
            xs[2] = ctr_x - a - 1; ys[2] = ctr_y + b;     en[2] = mask_q[QB_MXPY];
            xs[3] = ctr_x + b;     ys[3] = ctr_y - a - 1; en[3] = mask_q[QB_PXMY];
            xs[4] = ctr_x + a;     ys[4] = ctr_y - b - 1; en[4] = mask_q[QB_PXMY];
            xs[5] = ctr_x - b - 1; ys[5] = ctr_y + a;     en[5] = mask_q[QB_MXPY];
            xs[6] = ctr_x - a - 1; ys[6] = ctr_y - b - 1; en[6] = mask_q[QB_MXMY];
            xs[7] = ctr_x - b - 1; ys[7] = ctr_y - a - 1; en[7] = mask_q[QB_MXMY];
            for (int k = 0; k < 8; k++) begin
                if (en[k] && xs[k] >= 0 && ys[k] >= 0 && xs[k] < w_lim && ys[k] < h_lim) begin
                    p        = '0;
                    p.x      = xs[k][PIX_W-1:0];
                    p.y      = ys[k][PIX_W-1:0];
                    p.color  = color_q;
                    p.pix_ok = 1'b1;
                    found.push_back(p);
                end
            end
            dec_err = dec_err + 2 * b + 2;
            off_b   = b + 1;
            if (dec_err >= 0) begin
                off_a   = a - 1;
                dec_err = dec_err - (2 * off_a + 1);
            end
            running = (off_a >= off_b);
        end
        if (found.size() == 0)
            found.push_back(status_result(1'b0));
        for (int k = 0; k < found.size(); k++) begin
            p      = found[k];
            p.last = (k == found.size() - 1);
            p.done = !running;
            if (!rq.typed)
                pixel_expect_q.push_back(p);
        end
        if (rq.typed)
            pixel_expect_q.push_back(rq.want);
    endfunction

    // Prediction first, then the result check, so a same-edge result still finds its entry.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) begin
                case (cfg_if.index)
                    CFG_IMAGE_WIDTH:  img_w = int'(cfg_if.data);
                    CFG_IMAGE_HEIGHT: img_h = int'(cfg_if.data);
                    default: ;
                endcase
            end
            if (req_if.valid && req_if.ready)
                predict_octant_step(req_now);
            if (pix_if.valid && pix_if.ready) begin
                seen_pixel.x      = pix_if.pixel_x;
                seen_pixel.y      = pix_if.pixel_y;
                seen_pixel.color  = pix_if.pixel_rgba;
                seen_pixel.pix_ok = pix_if.pixel_valid;
                seen_pixel.last   = pix_if.last_of_step;
                seen_pixel.done   = pix_if.circle_done;
                if (pixel_expect_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected pixel transfer, expected none, actual x=%0d y=%0d ",
                             $time, seen_pixel.x, seen_pixel.y,
                             "color=%h pixel=%b last=%b done=%b", seen_pixel.color,
                             seen_pixel.pix_ok, seen_pixel.last, seen_pixel.done);
                end else begin
                    want_pixel = pixel_expect_q.pop_front();
                    if (seen_pixel !== want_pixel) begin
                        mismatch_count++;
                        $display("%0t: pixel mismatch, expected x=%0d y=%0d color=%h ",
                                 $time, want_pixel.x, want_pixel.y, want_pixel.color,
                                 "pixel=%b last=%b done=%b, actual x=%0d y=%0d color=%h ",
                                 want_pixel.pix_ok, want_pixel.last, want_pixel.done,
                                 seen_pixel.x, seen_pixel.y, seen_pixel.color,
                                 "pixel=%b last=%b done=%b",
                                 seen_pixel.pix_ok, seen_pixel.last, seen_pixel.done);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("midpoint_circle_octant_stepper_tb: done, errors");
            $finish;
        end
    end

    always @(negedge i_clk)
        pix_if.ready = ($urandom_range(99) >= recv_stall_pct);

    task automatic add_row(input logic kind, input int cx, input int cy, input int r,
                           input logic [MASK_W-1:0] mask, input logic [COLOR_W-1:0] color,
                           input bit typed, input t_pixel want);
        t_circle_req row;
        row.kind   = kind;
        row.cx     = cx[CTR_W-1:0];
        row.cy     = cy[CTR_W-1:0];
        row.radius = r[RAD_W-1:0];
        row.mask   = mask;
        row.color  = color;
        row.typed  = typed;
        row.want   = want;
        directed_rows.push_back(row);
    endtask

    function automatic t_circle_req rand_row(input logic kind);
        t_circle_req row;
        row.kind   = kind;
        row.cx     = CTR_W'($urandom);
        row.cy     = CTR_W'($urandom);
        row.radius = RAD_W'($urandom);
        row.mask   = MASK_W'($urandom);
        row.color  = $urandom;
        row.typed  = 1'b0;
        row.want   = '0;
        return row;
    endfunction

    function automatic int pick_pos(input int lim);
        int span;
        span = (lim > MAX_DIM) ? MAX_DIM : lim;
        return int'($urandom_range(0, span + 40)) - 20;
    endfunction

    task automatic send_req(input t_circle_req rq);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid    = 1'b0;
            req_if.req_type = 1'($urandom);
            req_if.center_x = CTR_W'($urandom);
            @(negedge i_clk);
        end
        req_now            = rq;
        req_if.valid       = 1'b1;
        req_if.req_type    = rq.kind;
        req_if.center_x    = rq.cx;
        req_if.center_y    = rq.cy;
        req_if.radius      = rq.radius;
        req_if.quadrant_en = rq.mask;
        req_if.draw_color  = rq.color;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    // stop requests and wait until every predicted pixel has come back
    task automatic settle();
        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (pixel_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge i_clk);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = value[CFG_W-1:0];
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic set_image(input int w, input int h);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
    endtask

    // Mostly whole circles with random content, some stray requests mixed in.
    task automatic run_phase(input int n_items, input bit hold_mid);
        t_circle_req rq;
        int          sent;
        int          steps;
        int          sel;
        bit          held;
        sent = 0;
        held = 1'b0;
        while (sent < n_items) begin
            if ($urandom_range(9) == 0) begin
                send_req(rand_row(1'($urandom_range(1))));
                sent++;
            end else begin
                rq = rand_row(REQ_START);
                rq.cx = CTR_W'(pick_pos(img_w));
                rq.cy = CTR_W'(pick_pos(img_h));
                sel = $urandom_range(19);
                if (sel < 16)
                    rq.radius = RAD_W'($urandom_range(1, 24));
                else if (sel == 16)
                    rq.radius = '0;
                if ($urandom_range(1))
                    rq.mask = 4'hF;
                send_req(rq);
                sent++;
                if (rq.radius > 40)
                    steps = $urandom_range(1, 4);
                else
                    steps = (int'(rq.radius) * 3) / 4 + $urandom_range(0, 2);
                if (steps > n_items - sent)
                    steps = n_items - sent;
                repeat (steps) begin
                    send_req(rand_row(REQ_STEP));
                    sent++;
                end
            end
            if (hold_mid && !held && sent >= n_items / 2) begin
                settle();
                held = 1'b1;
            end
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        req_if.valid       = 1'b0;
        req_if.req_type    = REQ_START;
        req_if.center_x    = '0;
        req_if.center_y    = '0;
        req_if.radius      = '0;
        req_if.quadrant_en = '0;
        req_if.draw_color  = '0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = CFG_IMAGE_WIDTH;
        cfg_if.data        = '0;
        pix_if.ready       = 1'b0;

        // reset image is 0 x 0, so everything before the first write is clipped
        add_row(REQ_STEP,  0, 0, 0, 4'hF, 32'h0, 1'b1, status_result(1'b1));
        add_row(REQ_START, 0, 0, 0, 4'hF, 32'hDEADBEEF, 1'b1, status_result(1'b1));
        add_row(REQ_STEP,  0, 0, 0, 4'hF, 32'h0, 1'b1, status_result(1'b1));
        add_row(REQ_START, 2, 2, 3, 4'hF, 32'h0000FFFF, 1'b1, status_result(1'b0));
        add_row(REQ_STEP,  0, 0, 0, 4'h0, 32'h0, 1'b1, status_result(1'b0));
        // 40 x 30 image from here
        add_row(REQ_START, 20, 15, 10, 4'hF, 32'hFFFFFFFF, 1'b0, '0);
        repeat (8) add_row(REQ_STEP, 0, 0, 0, 4'h0, 32'h0, 1'b0, '0);
        add_row(REQ_START, 0, 0, 4, 4'hF, 32'h12345678, 1'b0, '0);
        repeat (2) add_row(REQ_STEP, 0, 0, 0, 4'h0, 32'h0, 1'b0, '0);
        add_row(REQ_START, -32768, 32767, 32767, 4'h8, 32'h0, 1'b1, status_result(1'b0));
        add_row(REQ_STEP,  0, 0, 0, 4'h0, 32'h0, 1'b0, '0);
        add_row(REQ_START, 32767, -32768, 1, 4'h1, 32'h80000001, 1'b1, status_result(1'b0));
        add_row(REQ_STEP,  0, 0, 0, 4'h0, 32'h0, 1'b1, status_result(1'b1));
        // radius one: all eight mirrored pixels land in the image
        add_row(REQ_START, 5, 5, 1, 4'hF, 32'hA5A5A5A5, 1'b0, '0);
        add_row(REQ_STEP,  0, 0, 0, 4'h0, 32'h0, 1'b0, '0);
        add_row(REQ_START, 39, 29, 3, 4'h2, 32'h0F0F0F0F, 1'b0, '0);
        add_row(REQ_STEP,  0, 0, 0, 4'h0, 32'h0, 1'b0, '0);
        add_row(REQ_START, 10, 10, 6, 4'h4, 32'h5555AAAA, 1'b0, '0);
        add_row(REQ_STEP,  0, 0, 0, 4'h0, 32'h0, 1'b0, '0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < directed_rows.size(); i++) begin
            if (i == SIZED_FROM) begin
                settle();
                set_image(40, 30);
            end
            send_req(directed_rows[i]);
        end

        settle();
        set_image(100, 80);
        write_reg(CFG_SPARE_2, $urandom);
        write_reg(CFG_SPARE_3, $urandom);
        run_phase(PHASE_ITEMS, 1'b0);

        settle();
        set_image(MAX_DIM, MAX_DIM);
        send_idle_pct  = 46;
        recv_stall_pct = 0;
        run_phase(PHASE_ITEMS, 1'b1);

        settle();
        set_image(8191, 8191);
        send_idle_pct  = 0;
        recv_stall_pct = 46;
        run_phase(PHASE_ITEMS, 1'b0);

        settle();
        set_image(64, 1);
        send_idle_pct  = 31;
        recv_stall_pct = 31;
        run_phase(PHASE_ITEMS / 3, 1'b0);
        settle();
        set_image(1, 64);
        run_phase(PHASE_ITEMS / 3, 1'b0);
        settle();
        set_image(64, 48);
        run_phase(PHASE_ITEMS, 1'b0);

        settle();
        if (mismatch_count == 0)
            $display("midpoint_circle_octant_stepper_tb: done, clean");
        else
            $display("midpoint_circle_octant_stepper_tb: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/mcos_pkg.sv
design/mcos_if.sv
design/midpoint_circle_octant_stepper.sv
dv/midpoint_circle_octant_stepper_tb.sv
